@@ hw/rtl/kal_pkg.sv @@
// ----------------------------------------------------------------------------
// kal_pkg
// shared types and codes for the keyed array list
// ----------------------------------------------------------------------------
package kal_pkg;

    localparam int KEY_W    = 16;
    localparam int HANDLE_W = 32;
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 6;

    // command codes
    localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LIST   = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_APPENDED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DELETED   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [STATUS_W-1:0] ST_LISTED    = 3'd4;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd5;

    // one stored entry
    typedef struct packed {
        logic [KEY_W-1:0]    key;
        logic [HANDLE_W-1:0] name;
        logic [HANDLE_W-1:0] job;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SRCH  = 5'b00010,
        S_SHIFT = 5'b00100,
        S_LIST  = 5'b01000,
        S_EMIT  = 5'b10000
    } t_state;

endpackage

@@ hw/rtl/kal_ram.sv @@
// ----------------------------------------------------------------------------
// kal_ram
// generic one-write one-read ram with registered read data
// ----------------------------------------------------------------------------
module kal_ram #(
    parameter int WIDTH = 80,
    parameter int DEPTH = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/keyed_array_list_append_delete.sv @@
// ----------------------------------------------------------------------------
// keyed_array_list_append_delete
// bounded ordered list of keyed entries with append, delete by key and list
// ----------------------------------------------------------------------------
//  channel   direction  handshake                 payload
//  in        to block   i_in_valid / o_in_stall   i_cmd, i_key, i_name_handle,
//                                                 i_job_handle
//  out       from block o_out_valid / i_out_stall o_status, o_entry_key,
//                                                 o_entry_name, o_entry_job,
//                                                 o_count_after, o_last
//
//  append, and delete or list on an empty list, loads its result beat
//  at the accept edge
//  delete walks the entry ram through its single read port, one entry a
//  cycle (search up to the match, move down of the later entries, then
//  load the result beat)
//  list gives one beat per stored entry per cycle while the output is not
//  stalled, after the registered ram read of the first entry
//  an input beat is taken only when the sequencer is idle and the output
//  register is empty or being drained
//  reset clears the count and the control state; the ram is not cleared,
//  entries at or above the count never reach a result, even if read
// ----------------------------------------------------------------------------
module keyed_array_list_append_delete
    import kal_pkg::*;
#(
    parameter int CAPACITY = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input beats
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [CMD_W-1:0]    i_cmd,
    input  logic [KEY_W-1:0]    i_key,
    input  logic [HANDLE_W-1:0] i_name_handle,
    input  logic [HANDLE_W-1:0] i_job_handle,
    // result beats
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [STATUS_W-1:0] o_status,
    output logic [KEY_W-1:0]    o_entry_key,
    output logic [HANDLE_W-1:0] o_entry_name,
    output logic [HANDLE_W-1:0] o_entry_job,
    output logic [COUNT_W-1:0]  o_count_after,
    output logic                o_last
);

    // ram address width and a counter width that can hold the capacity itself
    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    // sequencer state
    t_state              r_state, n_state;
    logic [CW-1:0]       r_count, n_count;
    logic [CW-1:0]       r_ptr,   n_ptr;    // next ram read index
    logic [CW-1:0]       r_idx,   n_idx;    // index of data now at ram output
    logic [KEY_W-1:0]    r_key,   n_key;    // request key
    logic [STATUS_W-1:0] r_pst,   n_pst;    // pending single-beat status

    // output register
    logic                r_ov, n_ov;
    logic [STATUS_W-1:0] r_os, n_os;
    logic [KEY_W-1:0]    r_ok, n_ok;
    logic [HANDLE_W-1:0] r_on, n_on;
    logic [HANDLE_W-1:0] r_oj, n_oj;
    logic [CW-1:0]       r_oc, n_oc;
    logic                r_ol, n_ol;

    // ram port
    logic          ram_we;
    logic [IW-1:0] ram_waddr;
    t_entry        ram_wdata;
    logic          ram_re;
    logic [IW-1:0] ram_raddr;
    t_entry        ram_rdata;

    logic          out_free;
    logic          in_acc;
    logic          chk_last;
    logic          key_hit;
    logic [CW-1:0] idx_m1;
    logic [CW+5:0] cnt_ext;

    kal_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // output register empty, or its beat leaves this cycle
    assign out_free   = !r_ov || !i_out_stall;
    assign o_in_stall = !((r_state == S_IDLE) && out_free);
    assign in_acc     = i_in_valid && !o_in_stall;

    // shared compare: key match and end-of-list on the entry at the ram output
    assign key_hit  = (ram_rdata.key == r_key);
    assign chk_last = ((r_idx + CW'(1)) == r_count);
    assign idx_m1   = r_idx - CW'(1);

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_ptr   = r_ptr;
        n_idx   = r_idx;
        n_key   = r_key;
        n_pst   = r_pst;
        n_ov    = r_ov;
        n_os    = r_os;
        n_ok    = r_ok;
        n_on    = r_on;
        n_oj    = r_oj;
        n_oc    = r_oc;
        n_ol    = r_ol;

        ram_we    = 1'b0;
        ram_waddr = r_count[IW-1:0];
        ram_wdata = '{key: i_key, name: i_name_handle, job: i_job_handle};
        ram_re    = 1'b0;
        ram_raddr = r_ptr[IW-1:0];

        // current beat taken downstream
        if (!i_out_stall) begin
            n_ov = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_key = i_key;
                    // single-beat result fields, overridden per command
                    n_ok  = i_key;
                    n_on  = '0;
                    n_oj  = '0;
                    n_ol  = 1'b1;
                    n_oc  = r_count;
                    unique case (i_cmd)
                        CMD_APPEND: begin
                            n_ov = 1'b1;
                            if (r_count >= CW'(CAPACITY)) begin
                                n_os = ST_FULL;
                            end else begin
                                ram_we  = 1'b1;
                                n_count = r_count + CW'(1);
                                n_oc    = r_count + CW'(1);
                                n_os    = ST_APPENDED;
                            end
                        end
                        CMD_DELETE: begin
                            if (r_count == '0) begin
                                n_ov = 1'b1;
                                n_os = ST_NOT_FOUND;
                            end else begin
                                ram_re    = 1'b1;
                                ram_raddr = '0;
                                n_idx     = '0;
                                n_ptr     = CW'(1);
                                n_state   = S_SRCH;
                            end
                        end
                        CMD_LIST: begin
                            if (r_count == '0) begin
                                n_ov = 1'b1;
                                n_os = ST_EMPTY;
                            end else begin
                                ram_re    = 1'b1;
                                ram_raddr = '0;
                                n_idx     = '0;
                                n_ptr     = CW'(1);
                                n_state   = S_LIST;
                            end
                        end
                        default: begin
                            // unused command, no result
                        end
                    endcase
                end
            end

            S_SRCH: begin
                // read ahead one entry while checking the current one
                ram_re = 1'b1;
                n_ptr  = r_ptr + CW'(1);
                n_idx  = r_ptr;
                if (key_hit) begin
                    if (chk_last) begin
                        n_count = r_count - CW'(1);
                        n_pst   = ST_DELETED;
                        n_state = S_EMIT;
                    end else begin
                        n_state = S_SHIFT;
                    end
                end else if (chk_last) begin
                    n_pst   = ST_NOT_FOUND;
                    n_state = S_EMIT;
                end
            end

            S_SHIFT: begin
                // entry at r_idx moves down one place
                ram_re    = 1'b1;
                n_ptr     = r_ptr + CW'(1);
                n_idx     = r_ptr;
                ram_we    = 1'b1;
                ram_waddr = idx_m1[IW-1:0];
                ram_wdata = ram_rdata;
                if (chk_last) begin
                    n_count = r_count - CW'(1);
                    n_pst   = ST_DELETED;
                    n_state = S_EMIT;
                end
            end

            S_LIST: begin
                if (out_free) begin
                    n_ov = 1'b1;
                    n_os = ST_LISTED;
                    n_ok = ram_rdata.key;
                    n_on = ram_rdata.name;
                    n_oj = ram_rdata.job;
                    n_oc = r_count;
                    n_ol = chk_last;
                    if (chk_last) begin
                        n_state = S_IDLE;
                    end else begin
                        ram_re = 1'b1;
                        n_ptr  = r_ptr + CW'(1);
                        n_idx  = r_ptr;
                    end
                end
            end

            S_EMIT: begin
                if (out_free) begin
                    n_ov    = 1'b1;
                    n_os    = r_pst;
                    n_ok    = r_key;
                    n_on    = '0;
                    n_oj    = '0;
                    n_oc    = r_count;
                    n_ol    = 1'b1;
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ov    <= n_ov;
        end
    end

    // walk indexes and payload
    always_ff @(posedge i_clk) begin
        r_ptr <= n_ptr;
        r_idx <= n_idx;
        r_key <= n_key;
        r_pst <= n_pst;
        r_os  <= n_os;
        r_ok  <= n_ok;
        r_on  <= n_on;
        r_oj  <= n_oj;
        r_oc  <= n_oc;
        r_ol  <= n_ol;
    end

    // count shown modulo 64
    assign cnt_ext = {6'd0, r_oc};

    assign o_out_valid   = r_ov;
    assign o_status      = r_os;
    assign o_entry_key   = r_ok;
    assign o_entry_name  = r_on;
    assign o_entry_job   = r_oj;
    assign o_count_after = cnt_ext[COUNT_W-1:0];
    assign o_last        = r_ol;

endmodule

@@ hw/rtl/kal_chk.sv @@
// ----------------------------------------------------------------------------
// kal_chk
// port-level checks for the keyed array list
// ----------------------------------------------------------------------------
module kal_chk
    import kal_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input logic [CMD_W-1:0]    i_cmd,
    input logic [KEY_W-1:0]    i_key,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input logic [STATUS_W-1:0] o_status,
    input logic [KEY_W-1:0]    o_entry_key,
    input logic [HANDLE_W-1:0] o_entry_name,
    input logic [HANDLE_W-1:0] o_entry_job,
    input logic [COUNT_W-1:0]  o_count_after,
    input logic                o_last
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_status)
            && $stable(o_entry_key) && $stable(o_entry_name)
            && $stable(o_entry_job) && $stable(o_count_after) && $stable(o_last))
        else $error("stalled result beat changed");

    // append answers in the next cycle with its own key
    a_append_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_cmd == CMD_APPEND) |=> o_out_valid
            && (o_status == ST_APPENDED || o_status == ST_FULL)
            && o_last && (o_entry_key == $past(i_key)))
        else $error("append result missing or wrong");

    // only listed entries carry payload or continue a sequence
    a_single_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != ST_LISTED) |->
            o_last && (o_entry_name == '0) && (o_entry_job == '0))
        else $error("single result beat malformed");

    // an empty list reports no entries
    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_EMPTY) |-> (o_count_after == '0))
        else $error("empty list with nonzero count");

endmodule

bind keyed_array_list_append_delete kal_chk u_kal_chk (.*);

@@ verif/tb_keyed_array_list_append_delete.sv @@
// ----------------------------------------------------------------------------
// tb_keyed_array_list_append_delete
// self-checking bench for the keyed array list: a shadow copy of the list
// predicts every result beat of append, delete by key and list; directed
// corner cases, a fill to capacity under long output back-pressure and a
// random mix with random gaps on both channels
// ----------------------------------------------------------------------------
module tb_keyed_array_list_append_delete
    import kal_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIST_CAP       = 32;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 80;
    localparam int RANDOM_ITEMS   = 260;

    // the package has no code for the fourth command, which the block ignores
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    // one result beat
    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [KEY_W-1:0]    key;
        logic [HANDLE_W-1:0] name;
        logic [HANDLE_W-1:0] job;
        logic [COUNT_W-1:0]  count;
        logic                last;
    } t_reply;

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                i_in_valid    = 1'b0;
    logic                o_in_stall;
    logic [CMD_W-1:0]    i_cmd         = '0;
    logic [KEY_W-1:0]    i_key         = '0;
    logic [HANDLE_W-1:0] i_name_handle = '0;
    logic [HANDLE_W-1:0] i_job_handle  = '0;
    logic                o_out_valid;
    logic                i_out_stall   = 1'b0;
    logic [STATUS_W-1:0] o_status;
    logic [KEY_W-1:0]    o_entry_key;
    logic [HANDLE_W-1:0] o_entry_name;
    logic [HANDLE_W-1:0] o_entry_job;
    logic [COUNT_W-1:0]  o_count_after;
    logic                o_last;

    // shadow copy of the list contents
    logic [KEY_W-1:0]    shadow_key  [LIST_CAP];
    logic [HANDLE_W-1:0] shadow_name [LIST_CAP];
    logic [HANDLE_W-1:0] shadow_job  [LIST_CAP];
    int                  shadow_count = 0;

    t_reply reply_q[$];
    int     fail_count = 0;

    // idling control shared by sender and receiver
    bit idle_on   = 1'b1;
    bit hold_req  = 1'b0;
    int hold_left = 0;
    int stall_run = 0;
    int quiet_cycles = 0;

    always #4 i_clk = ~i_clk;

    keyed_array_list_append_delete #(
        .CAPACITY(LIST_CAP)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_cmd         (i_cmd),
        .i_key         (i_key),
        .i_name_handle (i_name_handle),
        .i_job_handle  (i_job_handle),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (o_status),
        .o_entry_key   (o_entry_key),
        .o_entry_name  (o_entry_name),
        .o_entry_job   (o_entry_job),
        .o_count_after (o_count_after),
        .o_last        (o_last)
    );

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        if (!idle_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void push_reply(logic [STATUS_W-1:0] status, logic [KEY_W-1:0] key,
                                       logic [HANDLE_W-1:0] name, logic [HANDLE_W-1:0] job,
                                       logic last);
        t_reply r;
        r.status = status;
        r.key    = key;
        r.name   = name;
        r.job    = job;
        r.count  = COUNT_W'(shadow_count);
        r.last   = last;
        reply_q.push_back(r);
    endfunction

    // update the shadow list for one accepted beat and queue its results
    function automatic void apply_list_op(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key,
                                          logic [HANDLE_W-1:0] name, logic [HANDLE_W-1:0] job);
        int pos;
        case (cmd)
            CMD_APPEND: begin
                if (shadow_count >= LIST_CAP) begin
                    push_reply(ST_FULL, key, '0, '0, 1'b1);
                end else begin
                    shadow_key[shadow_count]  = key;
                    shadow_name[shadow_count] = name;
                    shadow_job[shadow_count]  = job;
                    shadow_count++;
                    push_reply(ST_APPENDED, key, '0, '0, 1'b1);
                end
            end
            CMD_DELETE: begin
                // first match wins, later entries move down one place
                pos = shadow_count;
                for (int i = 0; i < shadow_count; i++) begin
                    if (shadow_key[i] == key) begin
                        pos = i;
                        break;
                    end
                end
                if (pos >= shadow_count) begin
                    push_reply(ST_NOT_FOUND, key, '0, '0, 1'b1);
                end else begin
                    for (int i = pos; i + 1 < shadow_count; i++) begin
                        shadow_key[i]  = shadow_key[i+1];
                        shadow_name[i] = shadow_name[i+1];
                        shadow_job[i]  = shadow_job[i+1];
                    end
                    shadow_count--;
                    push_reply(ST_DELETED, key, '0, '0, 1'b1);
                end
            end
            CMD_LIST: begin
                if (shadow_count == 0) begin
                    push_reply(ST_EMPTY, key, '0, '0, 1'b1);
                end else begin
                    for (int i = 0; i < shadow_count; i++)
                        push_reply(ST_LISTED, shadow_key[i], shadow_name[i], shadow_job[i],
                                   i + 1 == shadow_count);
                end
            end
            default: ; // unused command: no change, no result
        endcase
    endfunction

    // drive one input beat, wait for its accept edge, then predict
    task automatic send_beat(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key,
                             logic [HANDLE_W-1:0] name, logic [HANDLE_W-1:0] job);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_cmd         <= cmd;
        i_key         <= key;
        i_name_handle <= name;
        i_job_handle  <= job;
        do @(posedge i_clk); while (o_in_stall);
        apply_list_op(cmd, key, name, job);
    endtask

    function automatic logic [HANDLE_W-1:0] rand_handle();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return $urandom;
    endfunction

    // stored keys most of the time so deletes hit, a small pool for duplicates
    function automatic logic [KEY_W-1:0] pick_key();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6 && shadow_count > 0) return shadow_key[$urandom_range(0, shadow_count - 1)];
        if (r < 8) return KEY_W'($urandom_range(0, 15));
        return KEY_W'($urandom);
    endfunction

    task automatic send_append();
        send_beat(CMD_APPEND, pick_key(), rand_handle(), rand_handle());
    endtask

    // receiver: random stall bursts, or one long hold when asked
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stall_run = 0;
            i_out_stall <= 1'b0;
        end else begin
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (stall_run > 0) begin
                stall_run--;
                i_out_stall <= 1'b1;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                stall_run = pick_gap();
                i_out_stall <= (stall_run > 0);
                if (stall_run > 0) stall_run--;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    task automatic check_field(string fld, logic [31:0] exp_v, logic [31:0] got_v);
        if (got_v !== exp_v) begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fld, exp_v, got_v);
        end
    endtask

    // result checker: every accepted beat against the oldest prediction
    always @(posedge i_clk) begin
        t_reply r;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (reply_q.size() == 0) begin
                fail_count++;
                $display("%0t: unexpected result beat, expected none, actual status %0d key %0h",
                         $time, o_status, o_entry_key);
            end else begin
                r = reply_q.pop_front();
                check_field("status", 32'(r.status), 32'(o_status));
                check_field("entry_key", 32'(r.key), 32'(o_entry_key));
                check_field("entry_name", r.name, o_entry_name);
                check_field("entry_job", r.job, o_entry_job);
                check_field("count_after", 32'(r.count), 32'(o_count_after));
                check_field("last", 32'(r.last), 32'(o_last));
            end
        end
    end

    // watchdog: cycles in a row with no beat on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: watchdog, no beat for %0d cycles", $time, quiet_cycles);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // empty list: list, delete and the ignored command
    task automatic test_empty_list();
        idle_on = 1'b1;
        send_beat(CMD_LIST, 16'h1234, '1, '1);
        send_beat(CMD_DELETE, 16'hA5A5, '0, '0);
        send_beat(CMD_UNUSED, 16'hFFFF, '1, '1);
        send_beat(CMD_LIST, 16'h0000, '0, '0);
    endtask

    // field extremes, duplicate keys and deletes at both ends, back to back
    task automatic test_edges();
        idle_on = 1'b0;
        send_beat(CMD_APPEND, 16'h0000, 32'h0000_0000, 32'h0000_0000);
        send_beat(CMD_APPEND, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_beat(CMD_APPEND, 16'h0000, 32'h5A5A_5A5A, 32'hA5A5_A5A5);
        send_beat(CMD_APPEND, 16'h8000, 32'h8000_0001, 32'h7FFF_FFFE);
        send_beat(CMD_LIST, 16'h0001, '0, '0);
        send_beat(CMD_DELETE, 16'h0000, '0, '0);   // removes the first of the two
        send_beat(CMD_LIST, 16'h0002, '0, '0);
        send_beat(CMD_DELETE, 16'h7777, '0, '0);   // not stored
        send_beat(CMD_UNUSED, 16'h0000, '0, '0);
        send_beat(CMD_DELETE, 16'h8000, '0, '0);   // last entry
        send_beat(CMD_DELETE, 16'hFFFF, '0, '0);   // first entry
        send_beat(CMD_LIST, 16'h0003, '0, '0);
        send_beat(CMD_DELETE, 16'h0000, '0, '0);   // list goes empty
        send_beat(CMD_LIST, 16'hFFFF, '1, '1);
    endtask

    // fill to capacity while the receiver holds off, then full and long shifts
    task automatic test_fill_backpressure();
        idle_on  = 1'b1;
        hold_req = 1'b1;
        while (shadow_count < LIST_CAP)
            send_append();
        repeat (3) send_append();
        send_beat(CMD_LIST, pick_key(), rand_handle(), rand_handle());
        send_beat(CMD_DELETE, shadow_key[0], rand_handle(), rand_handle());
        send_append();
        send_beat(CMD_DELETE, shadow_key[shadow_count - 1], rand_handle(), rand_handle());
        send_beat(CMD_LIST, pick_key(), rand_handle(), rand_handle());
    endtask

    // random mix in alternating grow and shrink phases
    task automatic test_random_mix(int n_items);
        int  r;
        bit  grow;
        logic [CMD_W-1:0] cmd;
        for (int i = 0; i < n_items; i++) begin
            grow    = ((i / 40) % 2) == 0;
            idle_on = ((i / 60) % 3) != 2;   // every third stretch runs without idling
            r = $urandom_range(0, 99);
            if (r < 2)                    cmd = CMD_UNUSED;
            else if (r < 10)              cmd = CMD_LIST;
            else if (r < (grow ? 75 : 35)) cmd = CMD_APPEND;
            else                          cmd = CMD_DELETE;
            send_beat(cmd, pick_key(), rand_handle(), rand_handle());
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        test_empty_list();
        test_edges();
        test_fill_backpressure();
        test_random_mix(RANDOM_ITEMS);

        i_in_valid <= 1'b0;
        while (reply_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
